// ===== design/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants and controller/datapath interface types for the linear
// interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_RUN_DEF     = 16;

    localparam int STEP_BITS      = 20;
    localparam int CHAN_BITS      = 2;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = STEP_BITS;

    localparam logic [STEP_BITS-1:0] STEP_RESET = 20'd65536;
    localparam logic [CHAN_BITS-1:0] CHAN_RESET = 2'd2;
    localparam logic [CHAN_BITS-1:0] CHAN_STEREO_MIN = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_RATIO    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 1'd1;

    typedef struct packed {
        logic load;
        logic mul;
        logic emit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic more;
        logic out_free;
    } ctrl_stat_t;

endpackage

// ===== design/linear_interp_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation time stretch of a mono or stereo frame stream.
//
//   channel   ports                                    width
//   input     s_valid s_ready s_sample_ch0/ch1         SAMPLE_BITS x2
//             s_first_frame s_last_frame               1 x2
//   output    m_valid m_ready m_out_ch0/ch1 m_run_last SAMPLE_BITS x2, 1
//   config    cfg_wr_en cfg_index cfg_wr_data          1, 1, 20
//
// For each frame the sequencer loads, then runs one multiply step and one
// round/emit step per result on the shared per-channel multiplier pair,
// then commits the frame.
// Reset clears phase, previous-frame flag and output valid; config returns to
// step 1.0 and stereo. A stalled output holds the sequencer in its emit step;
// the input is taken again once the frame is committed.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
    parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN     = lir_pkg::MAX_RUN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_ch1,
    input  logic                               s_first_frame,
    input  logic                               s_last_frame,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_out_ch0,
    output logic signed [SAMPLE_BITS-1:0]      m_out_ch1,
    output logic                               m_run_last,
    input  logic                               cfg_wr_en,
    input  logic [lir_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lir_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data
);
    import lir_pkg::*;

    logic [STEP_BITS-1:0] step_ratio_reg;
    logic [CHAN_BITS-1:0] chan_count_reg;
    logic                 mono;
    ctrl_cmd_t            cmd;
    ctrl_stat_t           stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ratio_reg <= STEP_RESET;
            chan_count_reg <= CHAN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STEP_RATIO: begin
                    step_ratio_reg <= cfg_wr_data[STEP_BITS-1:0];
                end
                REG_CHANNEL_COUNT: begin
                    chan_count_reg <= cfg_wr_data[CHAN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign mono = chan_count_reg < CHAN_STEREO_MIN;

    lir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lir_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .MAX_RUN     (MAX_RUN)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .step_ratio   (step_ratio_reg),
        .mono         (mono),
        .in_ch0       (s_sample_ch0),
        .in_ch1       (s_sample_ch1),
        .in_first     (s_first_frame),
        .in_last      (s_last_frame),
        .out_ch0      (m_out_ch0),
        .out_ch1      (m_out_ch1),
        .out_run_last (m_run_last),
        .out_valid    (m_valid),
        .out_ready    (m_ready)
    );

endmodule

// ===== design/lir_ctrl.sv =====
// ----------------------------------------------------------------------------
// lir_ctrl
// Sequencer for one input frame: load, then alternate multiply and emit until
// the interval is exhausted, the run limit is hit or no previous frame is held, then commit the frame.
// ----------------------------------------------------------------------------
module lir_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lir_pkg::ctrl_stat_t stat,
    output lir_pkg::ctrl_cmd_t  cmd
);
    import lir_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (stat.more) begin
                    cmd.mul    = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/lir_datapath.sv =====
// ----------------------------------------------------------------------------
// lir_datapath
// Frame store, phase accumulator, per-channel multiply and rounding, and the
// output register.
// ----------------------------------------------------------------------------
module lir_datapath #(
    parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN     = lir_pkg::MAX_RUN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lir_pkg::ctrl_cmd_t            cmd,
    output lir_pkg::ctrl_stat_t           stat,
    input  logic [lir_pkg::STEP_BITS-1:0] step_ratio,
    input  logic                          mono,
    input  logic signed [SAMPLE_BITS-1:0] in_ch0,
    input  logic signed [SAMPLE_BITS-1:0] in_ch1,
    input  logic                          in_first,
    input  logic                          in_last,
    output logic signed [SAMPLE_BITS-1:0] out_ch0,
    output logic signed [SAMPLE_BITS-1:0] out_ch1,
    output logic                          out_run_last,
    output logic                          out_valid,
    input  logic                          out_ready
);
    import lir_pkg::*;

    localparam int PH_W   = ((FRAC_BITS > STEP_BITS) ? FRAC_BITS : STEP_BITS) + 1;
    localparam int CNT_W  = $clog2(MAX_RUN + 1);
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
    localparam logic [PH_W-1:0]   PHASE_ONE = PH_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF      = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [CNT_W-1:0]  RUN_MAX   = CNT_W'(MAX_RUN);

    logic signed [SAMPLE_BITS-1:0] cur0_reg, cur1_reg;
    logic signed [SAMPLE_BITS-1:0] prev0_reg, prev1_reg;
    logic signed [PROD_W-1:0]      prod0_reg, prod1_reg;
    logic signed [SAMPLE_BITS-1:0] out0_reg, out1_reg;
    logic [PH_W-1:0]               phase_reg, phase_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          have_prev_reg, have_prev_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          last_reg;
    logic                          pend_last_reg;
    logic                          run_last_reg;

    logic signed [SAMPLE_BITS-1:0] prev1_eff;
    logic                          phase_lt_one;
    logic [PH_W-1:0]               phase_sum;
    logic [CNT_W-1:0]              cnt_inc;
    logic signed [FRAC_BITS:0]     frac;
    logic signed [SAMPLE_BITS:0]   diff0, diff1;
    logic signed [PROD_W-1:0]      prod0, prod1;
    logic signed [PROD_W-1:0]      acc0, acc1;

    always_comb begin
        prev1_eff    = mono ? '0 : prev1_reg;
        phase_lt_one = phase_reg < PHASE_ONE;
        phase_sum    = phase_reg + PH_W'(step_ratio);
        cnt_inc      = cnt_reg + CNT_W'(1);
        frac         = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});
        diff0        = (SAMPLE_BITS+1)'(cur0_reg) - (SAMPLE_BITS+1)'(prev0_reg);
        diff1        = (SAMPLE_BITS+1)'(cur1_reg) - (SAMPLE_BITS+1)'(prev1_eff);
        prod0        = PROD_W'(diff0) * PROD_W'(frac);
        prod1        = PROD_W'(diff1) * PROD_W'(frac);
        acc0         = (PROD_W'(prev0_reg) <<< FRAC_BITS) + prod0_reg + $signed(HALF);
        acc1         = (PROD_W'(prev1_eff) <<< FRAC_BITS) + prod1_reg + $signed(HALF);
        stat.more     = have_prev_reg && phase_lt_one && (cnt_reg < RUN_MAX);
        stat.out_free = !out_valid_reg || out_ready;
    end

    // control state
    always_comb begin
        phase_next     = phase_reg;
        have_prev_next = have_prev_reg;
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load && in_first) begin
            phase_next     = '0;
            have_prev_next = 1'b0;
        end
        if (cmd.emit) begin
            phase_next     = phase_sum;
            out_valid_next = 1'b1;
        end
        if (cmd.finish) begin
            have_prev_next = !last_reg;
            if (last_reg) begin
                phase_next = '0;
            end else if (have_prev_reg && !phase_lt_one) begin
                phase_next = phase_reg - PHASE_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur0_reg <= in_ch0;
            cur1_reg <= mono ? '0 : in_ch1;
            last_reg <= in_last;
            cnt_reg  <= '0;
        end
        if (cmd.mul) begin
            prod0_reg     <= prod0;
            prod1_reg     <= prod1;
            pend_last_reg <= !((phase_sum < PHASE_ONE) && (cnt_inc < RUN_MAX));
        end
        if (cmd.emit) begin
            out0_reg     <= acc0[FRAC_BITS +: SAMPLE_BITS];
            out1_reg     <= acc1[FRAC_BITS +: SAMPLE_BITS];
            run_last_reg <= pend_last_reg;
            cnt_reg      <= cnt_inc;
        end
        if (cmd.finish) begin
            prev0_reg <= last_reg ? '0 : cur0_reg;
            prev1_reg <= last_reg ? '0 : cur1_reg;
        end
    end

    assign out_ch0      = out0_reg;
    assign out_ch1      = out1_reg;
    assign out_run_last = run_last_reg;
    assign out_valid    = out_valid_reg;

endmodule
